@@ src/srle_pkg.sv @@
`default_nettype none

package srle_pkg;

  // Decode modes held in the mode register. Code 3 decodes as raw.
  localparam logic [1:0] MODE_RAW      = 2'd0;
  localparam logic [1:0] MODE_BYTE_RLE = 2'd1;
  localparam logic [1:0] MODE_WORD_RLE = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_COUNT = 2'd1;

  localparam logic [31:0] PIXEL_COUNT_RESET = 32'd1;

  // Result queue depth; must be a power of two and at least two.
  localparam int unsigned OUT_DEPTH = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic [15:0] repeat_res;
    logic        last_pixel;
    logic        error;
  } out_t;

  typedef struct packed {
    logic                   en;
    logic [CFG_INDEX_W-1:0] index;
    logic [31:0]            data;
  } cfg_wr_t;

  // Results produced by one byte: count is 0, 1 or 2, slot0 is filled first.
  typedef struct packed {
    logic [1:0] count;
    out_t       slot0;
    out_t       slot1;
  } push_t;

endpackage

`default_nettype wire

@@ src/srle_in_reg.sv @@
`default_nettype none

module srle_in_reg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         byte_valid,
  output logic              byte_stall,
  input  wire srle_pkg::in_t byte_word,
  input  wire logic         take,
  output logic              held_valid,
  output srle_pkg::in_t     held_item
);

  logic accept;

  assign byte_stall = held_valid & ~take;
  assign accept     = byte_valid & ~byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_item <= byte_word;
    end
  end

endmodule

`default_nettype wire

@@ src/srle_decode.sv @@
`default_nettype none

module srle_decode (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire srle_pkg::cfg_wr_t cfg,
  input  wire logic             item_valid,
  input  wire srle_pkg::in_t    item,
  input  wire logic             room,
  output logic                  take,
  output srle_pkg::push_t       push
);

  typedef enum logic [2:0] {
    PH_REC    = 3'd0,
    PH_SECOND = 3'd1,
    PH_VAL_LO = 3'd2,
    PH_VAL_HI = 3'd3,
    PH_LIT_LO = 3'd4,
    PH_LIT_HI = 3'd5
  } phase_t;

  logic [1:0]  mode;
  logic [31:0] pixel_count;
  phase_t      phase;
  logic [7:0]  held_byte;
  logic        half_pending;
  logic [15:0] record_count;
  logic [15:0] literal_left;
  logic [31:0] pixels_left;
  logic        finished;

  phase_t      phase_next;
  logic [7:0]  held_byte_next;
  logic        half_pending_next;
  logic [15:0] record_count_next;
  logic [15:0] literal_left_next;
  logic [31:0] pixels_left_next;
  logic        finished_next;

  logic [7:0]  b;
  logic        done_already;
  logic [15:0] e0_pix, e0_rep, e1_pix, e1_rep;
  logic [32:0] bytes_left;
  logic [15:0] nb, nb_rest;
  logic        first_half;
  logic [15:0] count_word, lit_dec;
  logic [16:0] rep_sum;
  logic        v0, v1, last0, last1, any_last;
  srle_pkg::out_t r0, r1;

  assign b    = item.data_byte;
  assign take = item_valid & room;
  assign done_already = finished | (pixels_left == 32'd0);

  // Byte RLE: bytes still needed to fill the frame, and the clipped run length.
  assign bytes_left = {pixels_left, 1'b0} - {32'd0, half_pending};
  assign nb         = ({17'd0, record_count} < bytes_left) ? record_count : bytes_left[15:0];
  assign first_half = half_pending & (nb != 16'd0);
  assign nb_rest    = nb - {15'd0, first_half};
  assign count_word = {b, held_byte};
  assign lit_dec    = literal_left - {15'd0, literal_left != 16'd0};

  always_comb begin
    phase_next        = phase;
    held_byte_next    = held_byte;
    half_pending_next = half_pending;
    record_count_next = record_count;
    literal_left_next = literal_left;
    e0_pix = {b, held_byte};
    e0_rep = 16'd0;
    e1_pix = {b, b};
    e1_rep = 16'd0;
    unique case (mode)
      srle_pkg::MODE_BYTE_RLE: begin
        if (phase == PH_REC) begin
          record_count_next = {{8{b[7]}}, b};
          phase_next        = PH_SECOND;
        end else begin
          phase_next = PH_REC;
          e0_rep     = {15'd0, first_half};
          e1_rep     = {1'b0, nb_rest[15:1]};
          if (first_half) begin
            half_pending_next = 1'b0;
          end
          if (nb_rest[0]) begin
            half_pending_next = 1'b1;
            held_byte_next    = b;
          end
        end
      end
      srle_pkg::MODE_WORD_RLE: begin
        unique case (phase)
          PH_SECOND: begin
            if (count_word[15]) begin
              literal_left_next = 16'd0 - count_word;
              phase_next        = PH_LIT_LO;
            end else begin
              record_count_next = count_word;
              phase_next        = PH_VAL_LO;
            end
          end
          PH_VAL_LO: begin
            held_byte_next = b;
            phase_next     = PH_VAL_HI;
          end
          PH_VAL_HI: begin
            e0_rep = ({16'd0, record_count} < pixels_left) ? record_count
                                                           : pixels_left[15:0];
            phase_next = PH_REC;
          end
          PH_LIT_LO: begin
            held_byte_next = b;
            phase_next     = PH_LIT_HI;
          end
          PH_LIT_HI: begin
            e0_rep            = 16'd1;
            literal_left_next = lit_dec;
            phase_next        = (lit_dec != 16'd0) ? PH_LIT_LO : PH_REC;
          end
          default: begin
            held_byte_next = b;
            phase_next     = PH_SECOND;
          end
        endcase
      end
      default: begin
        if (phase == PH_REC) begin
          held_byte_next = b;
          phase_next     = PH_SECOND;
        end else begin
          phase_next = PH_REC;
          e0_rep     = 16'd1;
        end
      end
    endcase
  end

  // Runs are clipped, so a run is the last one exactly when it reaches the remainder.
  assign rep_sum  = {1'b0, e0_rep} + {1'b0, e1_rep};
  assign v0       = e0_rep != 16'd0;
  assign v1       = e1_rep != 16'd0;
  assign last0    = {16'd0, e0_rep} >= pixels_left;
  assign last1    = {15'd0, rep_sum} >= pixels_left;
  assign any_last = (v0 & last0) | (v1 & last1);
  assign pixels_left_next = pixels_left - {15'd0, rep_sum};
  assign finished_next    = any_last | item.end_of_data;

  always_comb begin
    r0 = '{pixel: e0_pix, repeat_res: e0_rep, last_pixel: last0, error: 1'b0};
    r1 = '{pixel: e1_pix, repeat_res: e1_rep, last_pixel: last1, error: 1'b0};
    push = '0;
    if (take && !done_already) begin
      if (item.end_of_data && !any_last) begin
        // Data ran out before the frame filled: only the error word goes out.
        push.count = 2'd1;
        push.slot0 = '{pixel: 16'd0, repeat_res: 16'd0, last_pixel: 1'b0, error: 1'b1};
      end else if (v0) begin
        push.count = v1 ? 2'd2 : 2'd1;
        push.slot0 = r0;
        push.slot1 = r1;
      end else begin
        push.count = {1'b0, v1};
        push.slot0 = r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= srle_pkg::MODE_RAW;
      pixel_count  <= srle_pkg::PIXEL_COUNT_RESET;
      phase        <= PH_REC;
      held_byte    <= 8'd0;
      half_pending <= 1'b0;
      record_count <= 16'd0;
      literal_left <= 16'd0;
      pixels_left  <= srle_pkg::PIXEL_COUNT_RESET;
      finished     <= 1'b0;
    end else if (cfg.en && (cfg.index == srle_pkg::CFG_MODE ||
                            cfg.index == srle_pkg::CFG_PIXEL_COUNT)) begin
      // Any register write restarts the frame.
      if (cfg.index == srle_pkg::CFG_MODE) begin
        mode        <= cfg.data[1:0];
        pixels_left <= pixel_count;
      end else begin
        pixel_count <= cfg.data;
        pixels_left <= cfg.data;
      end
      phase        <= PH_REC;
      held_byte    <= 8'd0;
      half_pending <= 1'b0;
      record_count <= 16'd0;
      literal_left <= 16'd0;
      finished     <= 1'b0;
    end else if (take) begin
      if (done_already) begin
        finished <= 1'b1;
      end else begin
        phase        <= phase_next;
        held_byte    <= held_byte_next;
        half_pending <= half_pending_next;
        record_count <= record_count_next;
        literal_left <= literal_left_next;
        pixels_left  <= pixels_left_next;
        finished     <= finished_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/srle_out_fifo.sv @@
`default_nettype none

module srle_out_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire srle_pkg::push_t push,
  output logic                 room,
  output logic                 run_valid,
  input  wire logic            run_stall,
  output srle_pkg::out_t       run_word
);

  localparam int unsigned PtrW = $clog2(srle_pkg::OUT_DEPTH);
  localparam int unsigned CntW = $clog2(srle_pkg::OUT_DEPTH + 1);

  srle_pkg::out_t slots [srle_pkg::OUT_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr, wr_ptr_plus1;
  logic [CntW-1:0] count;
  logic            pop;

  assign wr_ptr_plus1 = wr_ptr + PtrW'(1);
  assign run_valid    = count != '0;
  assign run_word     = slots[rd_ptr];
  assign pop          = run_valid & ~run_stall;
  // Room for the two words a single byte can produce; the pop is left out
  // so that no path runs from the output stall to the input side.
  assign room = count <= CntW'(srle_pkg::OUT_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + CntW'(push.count) - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.slot0;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr_plus1] <= push.slot1;
    end
  end

endmodule

`default_nettype wire

@@ src/sprite_rle_pixel_decoder.sv @@
`default_nettype none

// Sprite RLE pixel decoder: takes one compressed byte per word on the byte
// channel and returns 16-bit pixels as (pixel, repeat) run words on the run
// channel, in raw, byte run-length or word run-length mode, until the
// programmed pixel count is reached; a frame whose data ends early yields a
// single error word. A byte is taken every cycle while the four-word result
// queue has room for two words; a byte that yields two runs occupies the
// single output port for two words, so sustained rate is one byte per cycle
// at one run per byte while run_stall is low, and lower otherwise. With the
// result queue empty, a byte's first run passes the input register and then
// the result queue before it appears. Writing either register restarts the
// frame and is allowed only while the block is idle.

module sprite_rle_pixel_decoder (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             byte_valid,
  output logic                                  byte_stall,
  input  wire srle_pkg::in_t                    byte_word,
  output logic                                  run_valid,
  input  wire logic                             run_stall,
  output srle_pkg::out_t                        run_word,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [srle_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]                      cfg_data
);

  logic              held_valid;
  srle_pkg::in_t     held_item;
  logic              take;
  logic              room;
  srle_pkg::push_t   push;
  srle_pkg::cfg_wr_t cfg;

  assign cfg_ready = 1'b1;
  assign cfg = '{en: cfg_valid, index: cfg_index, data: cfg_data};

  srle_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  srle_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (held_valid),
    .item       (held_item),
    .room       (room),
    .take       (take),
    .push       (push)
  );

  srle_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .run_valid (run_valid),
    .run_stall (run_stall),
    .run_word  (run_word)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BYTES = 1550;

  // Index codes past the two real registers; writes to them must change nothing.
  localparam logic [srle_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [srle_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  // The unused mode code decodes as raw.
  localparam logic [1:0] MODE_SPARE_3 = 2'd3;

  typedef enum logic [2:0] {
    PH_FIRST, PH_SECOND, PH_REP_LO, PH_REP_HI, PH_LIT_LO, PH_LIT_HI
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_stall;
  srle_pkg::in_t byte_word = '0;
  logic run_valid;
  logic run_stall = 1'b0;
  srle_pkg::out_t run_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [srle_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sprite_rle_pixel_decoder i_dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_word(byte_word),
    .run_valid(run_valid),
    .run_stall(run_stall),
    .run_word(run_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder state as the block should hold it.
  logic [1:0] cfg_mode = srle_pkg::MODE_RAW;
  logic [31:0] cfg_pixels = srle_pkg::PIXEL_COUNT_RESET;
  phase_t dec_phase = PH_FIRST;
  logic [7:0] held_byte = '0;
  logic half_pending = 1'b0;
  logic [15:0] run_len = '0;
  logic [15:0] literals_left = '0;
  logic [31:0] pixels_done = '0;
  logic frame_done = 1'b0;

  srle_pkg::out_t byte_runs[$];
  srle_pkg::out_t expected_runs[$];
  logic [7:0] frame_bytes[$];

  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit steady = 1'b0;
  int stall_left = 0;
  int stall_style = 0;

  function automatic void clear_decoder();
    dec_phase = PH_FIRST;
    held_byte = '0;
    half_pending = 1'b0;
    run_len = '0;
    literals_left = '0;
    pixels_done = '0;
    frame_done = 1'b0;
  endfunction

  function automatic void add_run(input logic [15:0] pix, input logic [31:0] rep);
    srle_pkg::out_t r;
    if (rep == 0 || byte_runs.size() >= 2) return;
    pixels_done = pixels_done + rep;
    r.pixel = pix;
    r.repeat_res = rep[15:0];
    r.last_pixel = (pixels_done >= cfg_pixels);
    r.error = 1'b0;
    if (r.last_pixel) frame_done = 1'b1;
    byte_runs.push_back(r);
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eod);
    logic [31:0] rem;
    logic [32:0] bytes_left;
    logic [32:0] nb;
    logic [15:0] c;
    srle_pkg::out_t err;
    byte_runs.delete();
    if (frame_done || pixels_done >= cfg_pixels) begin
      frame_done = 1'b1;
      return;
    end
    rem = cfg_pixels - pixels_done;
    if (cfg_mode == srle_pkg::MODE_BYTE_RLE) begin
      if (dec_phase == PH_FIRST) begin
        run_len = (b < 8'd128) ? {8'd0, b} : {8'hFF, b};
        dec_phase = PH_SECOND;
      end else begin
        bytes_left = {rem, 1'b0} - {32'd0, half_pending};
        nb = ({17'd0, run_len} < bytes_left) ? {17'd0, run_len} : bytes_left;
        dec_phase = PH_FIRST;
        // A byte held from the previous run completes its pixel first.
        if (half_pending && nb != 0) begin
          half_pending = 1'b0;
          add_run({b, held_byte}, 32'd1);
          nb = nb - 1;
        end
        add_run({b, b}, nb[32:1]);
        if (nb[0]) begin
          half_pending = 1'b1;
          held_byte = b;
        end
      end
    end else if (cfg_mode == srle_pkg::MODE_WORD_RLE) begin
      case (dec_phase)
        PH_SECOND: begin
          c = {b, held_byte};
          if (c[15]) begin
            literals_left = -c;
            dec_phase = PH_LIT_LO;
          end else begin
            run_len = c;
            dec_phase = PH_REP_LO;
          end
        end
        PH_REP_LO: begin
          held_byte = b;
          dec_phase = PH_REP_HI;
        end
        PH_REP_HI: begin
          add_run({b, held_byte}, ({16'd0, run_len} < rem) ? {16'd0, run_len} : rem);
          dec_phase = PH_FIRST;
        end
        PH_LIT_LO: begin
          held_byte = b;
          dec_phase = PH_LIT_HI;
        end
        PH_LIT_HI: begin
          add_run({b, held_byte}, 32'd1);
          if (literals_left != 0) literals_left = literals_left - 1;
          dec_phase = (literals_left != 0) ? PH_LIT_LO : PH_FIRST;
        end
        default: begin
          held_byte = b;
          dec_phase = PH_SECOND;
        end
      endcase
    end else begin
      if (dec_phase == PH_FIRST) begin
        held_byte = b;
        dec_phase = PH_SECOND;
      end else begin
        dec_phase = PH_FIRST;
        add_run({b, held_byte}, 32'd1);
      end
    end
    // Data that runs out early replaces everything this byte produced.
    if (eod && !frame_done) begin
      frame_done = 1'b1;
      err = '0;
      err.error = 1'b1;
      byte_runs.delete();
      byte_runs.push_back(err);
    end
    foreach (byte_runs[i]) expected_runs.push_back(byte_runs[i]);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eod);
    int gap;
    srle_pkg::in_t w;
    gap = 0;
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = $urandom_range(1, 6);
      end
      burst_left = burst_left - 1;
    end
    if (gap != 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.data_byte = b;
    w.end_of_data = eod;
    byte_valid <= 1'b1;
    byte_word <= w;
    do @(posedge clk); while (byte_stall !== 1'b0);
    decode_byte(b, eod);
  endtask

  task automatic write_reg(input logic [srle_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] val, input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (!hold) cfg_valid <= 1'b0;
    if (idx == srle_pkg::CFG_MODE) begin
      cfg_mode = val[1:0];
      clear_decoder();
    end else if (idx == srle_pkg::CFG_PIXEL_COUNT) begin
      cfg_pixels = val;
      clear_decoder();
    end
  endtask

  // Some bytes yield no run, so after the last expected run the bench waits
  // out a settle time before anything is reprogrammed.
  task automatic wait_idle();
    byte_valid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic build_frame(input logic [1:0] m, input logic [31:0] pc);
    longint need;
    int sel;
    int cnt;
    int take;
    logic [7:0] c;
    logic [15:0] w;
    frame_bytes.delete();
    need = pc;
    if (m == srle_pkg::MODE_BYTE_RLE) begin
      need = 2 * need;
      while (need > 0) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) c = 8'd0;
        else if (sel == 1) c = 8'($urandom_range(128, 255));
        else c = 8'($urandom_range(1, 9));
        frame_bytes.push_back(c);
        frame_bytes.push_back(8'($urandom));
        cnt = (c < 8'd128) ? int'(c) : 65280 + int'(c);
        need = (cnt >= need) ? 0 : need - cnt;
      end
    end else if (m == srle_pkg::MODE_WORD_RLE) begin
      while (need > 0) begin
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
          cnt = (sel == 0) ? 32768 : $urandom_range(1, 6);
          w = 16'(65536 - cnt);
          take = (cnt < need) ? cnt : int'(need);
        end else begin
          cnt = (sel == 4) ? 0 : (sel == 5) ? 32767 : $urandom_range(1, 9);
          w = 16'(cnt);
          take = 1;
        end
        frame_bytes.push_back(w[7:0]);
        frame_bytes.push_back(w[15:8]);
        repeat (take) begin
          frame_bytes.push_back(8'($urandom));
          frame_bytes.push_back(8'($urandom));
        end
        if (sel < 4) need = need - take;
        else need = (cnt >= need) ? 0 : need - cnt;
      end
    end else begin
      repeat (2 * need) frame_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic test_raw_words();
    wait_idle();
    write_reg(srle_pkg::CFG_MODE, {30'd0, srle_pkg::MODE_RAW}, 1'b1);
    write_reg(srle_pkg::CFG_PIXEL_COUNT, 32'd2, 1'b0);
    send_byte(8'h00, 1'b0);
    wait_idle();
    // A spare index leaves the half-built pixel in place.
    write_reg(CFG_SPARE_3, 32'hFFFF_FFFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic test_byte_runs();
    wait_idle();
    write_reg(srle_pkg::CFG_MODE, {30'd0, srle_pkg::MODE_BYTE_RLE}, 1'b1);
    write_reg(srle_pkg::CFG_PIXEL_COUNT, 32'd3, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hCD, 1'b1);
  endtask

  task automatic test_word_runs();
    wait_idle();
    write_reg(srle_pkg::CFG_MODE, {30'd0, srle_pkg::MODE_WORD_RLE}, 1'b1);
    write_reg(srle_pkg::CFG_PIXEL_COUNT, 32'd3, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h56, 1'b0);
  endtask

  task automatic test_frame_limits();
    wait_idle();
    write_reg(srle_pkg::CFG_MODE, {30'd0, MODE_SPARE_3}, 1'b1);
    write_reg(srle_pkg::CFG_PIXEL_COUNT, 32'hFFFF_FFFF, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    wait_idle();
    write_reg(srle_pkg::CFG_PIXEL_COUNT, 32'd0, 1'b0);
    send_byte(8'hC3, 1'b1);
  endtask

  task automatic test_random_frames();
    int sent;
    int cut;
    bit noise;
    logic [1:0] m;
    logic [31:0] pc;
    logic eod_last;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      wait_idle();
      noise = ($urandom_range(0, 7) == 0);
      m = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 11) == 0) m = MODE_SPARE_3;
      pc = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 150) : $urandom_range(1, 24);
      if (noise) pc = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 40);
      if ($urandom_range(0, 9) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom, 1'b1);
      write_reg(srle_pkg::CFG_MODE, {30'($urandom), m}, 1'b1);
      write_reg(srle_pkg::CFG_PIXEL_COUNT, pc, 1'b0);
      if (noise) begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 40)) frame_bytes.push_back(8'($urandom));
      end else begin
        build_frame(m, pc);
      end
      cut = frame_bytes.size();
      if ($urandom_range(0, 5) == 0) cut = $urandom_range(1, cut);
      eod_last = (cut < frame_bytes.size()) ? ($urandom_range(0, 3) != 0)
                                            : 1'($urandom_range(0, 1));
      steady = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < cut; i++) send_byte(frame_bytes[i], (i == cut - 1) ? eod_last : 1'b0);
      sent = sent + cut;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'($urandom));
    end
    steady = 1'b0;
  endtask

  // The run receiver picks a new stall habit whenever its current spell runs out.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 150);
    end
    stall_left = stall_left - 1;
    case (stall_style)
      0: run_stall <= 1'b0;
      1: run_stall <= ($urandom_range(0, 3) == 0);
      2: run_stall <= ($urandom_range(0, 3) != 0);
      default: run_stall <= ((stall_left % 12) < 7);
    endcase
  end

  always @(posedge clk) begin
    srle_pkg::out_t want;
    if (!rst && run_valid === 1'b1 && run_stall == 1'b0) begin
      if (expected_runs.size() == 0) begin
        $error("run word %h arrived with no run expected", run_word);
        mismatches++;
      end else begin
        want = expected_runs.pop_front();
        if (run_word.pixel !== want.pixel) begin
          $error("pixel: expected %h, got %h", want.pixel, run_word.pixel);
          mismatches++;
        end
        if (run_word.repeat_res !== want.repeat_res) begin
          $error("repeat_res: expected %0d, got %0d", want.repeat_res, run_word.repeat_res);
          mismatches++;
        end
        if (run_word.last_pixel !== want.last_pixel) begin
          $error("last_pixel: expected %b, got %b", want.last_pixel, run_word.last_pixel);
          mismatches++;
        end
        if (run_word.error !== want.error) begin
          $error("error: expected %b, got %b", want.error, run_word.error);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sprite_rle_pixel_decoder");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_raw_words();
    test_byte_runs();
    test_word_runs();
    test_frame_limits();
    test_random_frames();
    wait_idle();
    if (mismatches == 0) begin
      $display("PASS sprite_rle_pixel_decoder");
    end else begin
      $display("FAIL sprite_rle_pixel_decoder");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/srle_pkg.sv
src/srle_in_reg.sv
src/srle_decode.sv
src/srle_out_fifo.sv
src/sprite_rle_pixel_decoder.sv
tb/testbench.sv
